### design/hdff_pkg.sv
// Shared types and constants for the hemicube delta form factor block.
// No dependencies; used by every module in the design folder.
`default_nettype none

package hdff_pkg;

	localparam int H_W      = 10;   // half width register
	localparam int IDX_W    = 10;   // pixel indices
	localparam int SQ_W     = 20;   // squares of 10-bit values
	localparam int D_W      = 22;   // sum of three squares
	localparam int DSQ_W    = 44;   // D*D
	localparam int C_W      = 59;
	localparam int C_LO_W   = 30;
	localparam int C_HI_W   = C_W - C_LO_W;
	localparam int X_W      = SQ_W + C_W;        // numerator N*C
	localparam int DEN_W    = DSQ_W + 8;         // D*D*2^8
	localparam int REM_W    = DEN_W;
	localparam int QUO_W    = 51;                // quotient is below 2^51 for inside pixels
	localparam int WEIGHT_W = 56;

	localparam logic [H_W-1:0] HALF_WIDTH_RESET = 10'd128;

	// 2^64/(12*pi), rounded
	localparam logic [C_W-1:0]    INV_12PI_Q64 = 59'd489315082983811198;
	localparam logic [C_LO_W-1:0] INV_LO = INV_12PI_Q64[C_LO_W-1:0];
	localparam logic [C_HI_W-1:0] INV_HI = INV_12PI_Q64[C_W-1:C_LO_W];

	// one stage of the divider chain
	typedef struct packed {
		logic             valid;
		logic             oor;
		logic [REM_W-1:0] rem;   // partial remainder, below den
		logic [QUO_W-1:0] num;   // numerator bits still to shift in, MSB next
		logic [DEN_W-1:0] den;
		logic [QUO_W-1:0] quo;
	} cell_bus_t;

endpackage

`default_nettype wire

### design/hemicube_delta_form_factor.sv
// Hemicube delta form factor: one weight per start taken while not busy, fully pipelined.
// A taken start passes through the front-end stages, the divider cell chain and the output register before done.
// Throughput: one request per cycle while busy is low; the 51-cell divider chain sets the depth.
// busy is high only in reset and until the ready register is set after it; done cannot be stalled.
// Reset: arst_n clears the pipeline valids and sets half_width to 128.
// Depends on hdff_pkg, hdff_front and hdff_cell.
`default_nettype none

module hemicube_delta_form_factor
	import hdff_pkg::*;
#(
	parameter int MAX_HALF_WIDTH = 512
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                action,
	input  logic [IDX_W-1:0]    row_index,
	input  logic [IDX_W-1:0]    col_index,
	input  logic                cfg_we,
	input  logic [H_W-1:0]      cfg_data,
	output logic                done,
	output logic [WEIGHT_W-1:0] weight,
	output logic                out_of_range
);

	localparam int LATENCY = QUO_W + 5;

	logic           ready_q;
	logic [H_W-1:0] h_q;
	logic           load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q <= 1'b0;
			h_q     <= HALF_WIDTH_RESET;
		end else begin
			ready_q <= 1'b1;
			if (cfg_we) begin
				h_q <= (int'(cfg_data) > MAX_HALF_WIDTH) ? H_W'(MAX_HALF_WIDTH) : cfg_data;
			end
		end
	end

	assign busy = ~ready_q;
	assign load = start & ready_q;

	cell_bus_t stage_bus [0:QUO_W];

	hdff_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.action    (action),
		.row_index (row_index),
		.col_index (col_index),
		.h         (h_q),
		.chain_in  (stage_bus[0])
	);

	for (genvar g = 0; g < QUO_W; g++) begin : g_cell
		hdff_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.prev   (stage_bus[g]),
			.next   (stage_bus[g+1])
		);
	end

	// round to nearest, ties up
	cell_bus_t      last;
	logic           round_up;
	logic [QUO_W:0] q_rnd;
	logic           done_q, oor_q;
	logic [WEIGHT_W-1:0] weight_q;

	always_comb begin
		last     = stage_bus[QUO_W];
		round_up = ({last.rem, 1'b0} >= {1'b0, last.den});
		q_rnd    = {1'b0, last.quo} + (QUO_W+1)'(round_up);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= last.valid;
		end
	end

	always_ff @(posedge clk) begin
		oor_q    <= last.oor;
		weight_q <= last.oor ? '0 : WEIGHT_W'(q_rnd);
	end

	assign done         = done_q;
	assign weight       = weight_q;
	assign out_of_range = oor_q;

	a_chain_entry: assert property (@(posedge clk) disable iff (!arst_n)
		stage_bus[0].valid && !stage_bus[0].oor |-> stage_bus[0].rem < stage_bus[0].den)
		else $error("initial remainder not below divisor");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LATENCY done)
		else $error("result strobe missing after fixed latency");

	a_weight_msbs: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> weight[WEIGHT_W-1:QUO_W+1] == '0)
		else $error("weight exceeds quotient bound");

	a_half_width_sat: assert property (@(posedge clk) disable iff (!arst_n)
		int'(h_q) <= MAX_HALF_WIDTH)
		else $error("half width above maximum");

endmodule

`default_nettype wire

### design/hdff_front.sv
// Front end: range check, distances, squares and the N*C product.
// Depends on hdff_pkg; feeds the divider chain with a registered cell_bus_t.
`default_nettype none

module hdff_front
	import hdff_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  logic             action,
	input  logic [IDX_W-1:0] row_index,
	input  logic [IDX_W-1:0] col_index,
	input  logic [H_W-1:0]   h,
	output cell_bus_t        chain_in
);

	// stage 1: range check and distances
	logic             v_s1, oor_s1, side_s1;
	logic [IDX_W-1:0] di_s1, dj_s1, k_s1;
	logic [H_W-1:0]   h_s1;

	logic [H_W:0]     full;
	logic             in_face;
	logic [IDX_W-1:0] di, dj_top;

	always_comb begin
		full    = {h, 1'b0};
		in_face = ({1'b0, row_index} < full) &&
			(action ? (col_index < h) : ({1'b0, col_index} < full));
		di      = (row_index >= h) ? row_index - h : h - row_index;
		dj_top  = (col_index >= h) ? col_index - h : h - col_index;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= load;
		end
	end

	always_ff @(posedge clk) begin
		oor_s1  <= ~in_face;
		side_s1 <= action;
		di_s1   <= di;
		dj_s1   <= action ? col_index : dj_top;
		k_s1    <= col_index;
		h_s1    <= h;
	end

	// stage 2: squares and N
	logic            v_s2, oor_s2;
	logic [SQ_W-1:0] di2_s2, dj2_s2, h2_s2, n_s2;
	logic [H_W-1:0]  nsel;

	assign nsel = side_s1 ? k_s1 : h_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		oor_s2 <= oor_s1;
		di2_s2 <= di_s1 * di_s1;
		dj2_s2 <= dj_s1 * dj_s1;
		h2_s2  <= h_s1 * h_s1;
		n_s2   <= oor_s1 ? '0 : nsel * h_s1;
	end

	// stage 3: D and the two partial products of N*C
	logic              v_s3, oor_s3;
	logic [D_W-1:0]    d_s3;
	logic [SQ_W+C_LO_W-1:0] plo_s3;
	logic [SQ_W+C_HI_W-1:0] phi_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		oor_s3 <= oor_s2;
		d_s3   <= D_W'(di2_s2) + D_W'(dj2_s2) + D_W'(h2_s2);
		plo_s3 <= n_s2 * INV_LO;
		phi_s3 <= n_s2 * INV_HI;
	end

	// stage 4: D*D and the full numerator
	logic             v_s4;
	cell_bus_t        pay_s4;
	logic [X_W-1:0]   x;
	logic [DSQ_W-1:0] dsq;

	always_comb begin
		x   = (X_W'(phi_s3) << C_LO_W) + X_W'(plo_s3);
		dsq = d_s3 * d_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		pay_s4.valid <= 1'b0;
		pay_s4.oor   <= oor_s3;
		pay_s4.rem   <= REM_W'(x[X_W-1:QUO_W]);
		pay_s4.num   <= x[QUO_W-1:0];
		pay_s4.den   <= {dsq, 8'b0};
		pay_s4.quo   <= '0;
	end

	always_comb begin
		chain_in       = pay_s4;
		chain_in.valid = v_s4;
	end

endmodule

`default_nettype wire

### design/hdff_cell.sv
// One restoring-division cell: shifts in a numerator bit, makes one quotient bit.
// Depends on hdff_pkg for cell_bus_t.
`default_nettype none

module hdff_cell
	import hdff_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cell_bus_t prev,
	output cell_bus_t next
);

	logic             valid_q;
	cell_bus_t        pay_q;
	cell_bus_t        nxt;
	logic [REM_W:0]   t, diff;
	logic             ge;

	always_comb begin
		t    = {prev.rem, prev.num[QUO_W-1]};
		diff = t - {1'b0, prev.den};
		ge   = (t >= {1'b0, prev.den});
		nxt       = prev;
		nxt.rem   = ge ? diff[REM_W-1:0] : t[REM_W-1:0];
		nxt.num   = {prev.num[QUO_W-2:0], 1'b0};
		nxt.quo   = {prev.quo[QUO_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= prev.valid;
		end
	end

	always_ff @(posedge clk) begin
		pay_q <= nxt;
	end

	always_comb begin
		next       = pay_q;
		next.valid = valid_q;
	end

	// remainder stays below the divisor for in-range items
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		prev.valid && !prev.oor && (prev.rem < prev.den) |=> next.rem < next.den)
		else $error("divider cell remainder out of bound");

endmodule

`default_nettype wire

### dv/hdff_checker.sv
// Scoreboard for hemicube_delta_form_factor: watches the request, config and result ports,
// predicts each weight from its own copy of half_width and compares in order.
// Depends on hdff_pkg.
module hdff_checker
	import hdff_pkg::*;
#(
	parameter int MAX_HALF_WIDTH = 512
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  logic                action,
	input  logic [IDX_W-1:0]    row_index,
	input  logic [IDX_W-1:0]    col_index,
	input  logic                cfg_we,
	input  logic [H_W-1:0]      cfg_data,
	input  logic                done,
	input  logic [WEIGHT_W-1:0] weight,
	input  logic                out_of_range,
	output int                  mismatches,
	output int                  outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [WEIGHT_W-1:0] weight;
		logic                oor;
	} pixel_weight_t;

	pixel_weight_t  weight_q[$];
	int unsigned    half_width;

	function automatic pixel_weight_t pixel_weight(input int unsigned h, input logic side,
			input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col);
		pixel_weight_t     res;
		int unsigned       i, j, di, dj;
		longint unsigned   n, d;
		logic [131:0]      num, den, q;
		i = row;
		j = col;
		res.weight = '0;
		res.oor = 1'b1;
		if (i >= 2 * h || (side ? j >= h : j >= 2 * h))
			return res;
		di = (i >= h) ? i - h : h - i;
		if (side) begin
			dj = j;
			n = longint'(j) * h;
		end else begin
			dj = (j >= h) ? j - h : h - j;
			n = longint'(h) * h;
		end
		d = longint'(di) * di + longint'(dj) * dj + longint'(h) * h;
		num = n;
		num = num * INV_12PI_Q64;
		den = d;
		den = (den * den) << 8;
		// round to nearest, ties up
		q = ((num << 1) + den) / (den << 1);
		res.weight = q[WEIGHT_W-1:0];
		res.oor = 1'b0;
		return res;
	endfunction

	task automatic log_mismatch(input string what, input pixel_weight_t exp_w,
			input pixel_weight_t got_w);
		if (mismatches < 10)
			$display("%t %s: expected weight %h oor %b, got weight %h oor %b", $realtime,
				what, exp_w.weight, exp_w.oor, got_w.weight, got_w.oor);
		mismatches++;
	endtask

	always @(posedge clk) begin : scoreboard
		pixel_weight_t got_w, exp_w;
		if (!arst_n) begin
			half_width = HALF_WIDTH_RESET;
			weight_q.delete();
			mismatches = 0;
		end else begin
			if (done) begin
				got_w.weight = weight;
				got_w.oor = out_of_range;
				if (weight_q.size() == 0) begin
					exp_w = '0;
					log_mismatch("result with no request pending", exp_w, got_w);
				end else begin
					exp_w = weight_q.pop_front();
					if (got_w !== exp_w)
						log_mismatch("weight mismatch", exp_w, got_w);
				end
			end
			if (start && !busy)
				weight_q.push_back(pixel_weight(half_width, action, row_index, col_index));
			// writes above the limit saturate
			if (cfg_we)
				half_width = (cfg_data > MAX_HALF_WIDTH) ? MAX_HALF_WIDTH : cfg_data;
		end
		outstanding = weight_q.size();
	end

endmodule

### dv/tb_top.sv
// Top of the hemicube_delta_form_factor testbench: clock, reset, request and config stimulus,
// watchdog and verdict. Checking lives in hdff_checker.
// Depends on hdff_pkg, hdff_checker and the design files.
module tb_top;
	import hdff_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_HW         = 512;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 64;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic                action;
	logic [IDX_W-1:0]    row_index;
	logic [IDX_W-1:0]    col_index;
	logic                cfg_we;
	logic [H_W-1:0]      cfg_data;
	logic                done;
	logic [WEIGHT_W-1:0] weight;
	logic                out_of_range;
	int                  mismatches;
	int                  outstanding;

	int          stall_cycles = 0;
	int          burst_left;
	int unsigned face_half = HALF_WIDTH_RESET;

	always #5 clk = ~clk;

	hemicube_delta_form_factor #(
		.MAX_HALF_WIDTH(MAX_HW)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.action      (action),
		.row_index   (row_index),
		.col_index   (col_index),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.done        (done),
		.weight      (weight),
		.out_of_range(out_of_range)
	);

	hdff_checker #(
		.MAX_HALF_WIDTH(MAX_HW)
	) checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.action      (action),
		.row_index   (row_index),
		.col_index   (col_index),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.done        (done),
		.weight      (weight),
		.out_of_range(out_of_range),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		while (stall_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("TB_ERROR");
		$finish;
	end

	task automatic send_pixel(input logic side, input logic [IDX_W-1:0] row,
			input logic [IDX_W-1:0] col);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				@(negedge clk);
				start <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		start <= 1'b1;
		action <= side;
		row_index <= row;
		col_index <= col;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic send_random_pixel();
		logic            side;
		logic [IDX_W-1:0] row, col;
		int unsigned     h;
		h = face_half;
		side = $urandom_range(0, 1);
		if (h == 0 || $urandom_range(0, 9) == 0) begin
			row = IDX_W'($urandom);
			col = IDX_W'($urandom);
		end else if ($urandom_range(0, 9) == 0) begin
			// hug the face border from both sides
			row = IDX_W'(2 * h - $urandom_range(0, 1));
			col = side ? IDX_W'(h - $urandom_range(0, 1)) : IDX_W'(2 * h - $urandom_range(0, 1));
		end else begin
			row = IDX_W'($urandom_range(0, 2 * h - 1));
			col = side ? IDX_W'($urandom_range(0, h - 1)) : IDX_W'($urandom_range(0, 2 * h - 1));
		end
		send_pixel(side, row, col);
	endtask

	// returns at a falling edge with the pipeline empty
	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_half_width(input logic [H_W-1:0] value);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		face_half = (value > MAX_HW) ? MAX_HW : value;
	endtask

	initial begin
		logic [H_W-1:0] cfg_plan[7];
		logic [H_W-1:0] cfg_value;
		cfg_plan = '{10'd1, 10'd512, 10'd1023, 10'd0, 10'd513, 10'd2, 10'd3};
		arst_n = 1'b0;
		start = 1'b0;
		action = 1'b0;
		row_index = '0;
		col_index = '0;
		cfg_we = 1'b0;
		cfg_data = '0;
		burst_left = 0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// corners, centre and just-outside pixels of both faces at the reset half width of 128
		send_pixel(1'b0, 10'd0, 10'd0);
		send_pixel(1'b0, 10'd128, 10'd128);
		send_pixel(1'b0, 10'd255, 10'd255);
		send_pixel(1'b0, 10'd255, 10'd0);
		send_pixel(1'b0, 10'd127, 10'd129);
		send_pixel(1'b0, 10'd256, 10'd0);
		send_pixel(1'b0, 10'd0, 10'd256);
		send_pixel(1'b0, 10'd1023, 10'd1023);
		send_pixel(1'b1, 10'd128, 10'd0);
		send_pixel(1'b1, 10'd128, 10'd1);
		send_pixel(1'b1, 10'd0, 10'd127);
		send_pixel(1'b1, 10'd255, 10'd127);
		send_pixel(1'b1, 10'd128, 10'd128);
		send_pixel(1'b1, 10'd256, 10'd5);
		send_pixel(1'b1, 10'd0, 10'd1023);
		send_pixel(1'b1, 10'd1023, 10'd0);

		// hold off mid-phase until the pipeline is empty
		repeat (70) send_random_pixel();
		wait_drained();
		repeat (70) send_random_pixel();

		for (int p = 0; p < 10; p++) begin
			cfg_value = (p < 7) ? cfg_plan[p] : H_W'($urandom_range(1, 1023));
			write_half_width(cfg_value);
			repeat ((face_half == 0) ? 50 : 150) send_random_pixel();
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
